// File: hw/rtl/tai_list_ie_decoder_core_defines.svh
// Assertion macros for the TAI list element decoder back end
`ifndef TAI_LIST_IE_DECODER_CORE_DEFINES_SVH
`define TAI_LIST_IE_DECODER_CORE_DEFINES_SVH

// same-cycle implication, clocked on clk, off during reset
`define TLE_ASSERT_HOLDS(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define TLE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/tle_pkg.sv
// Types, constants and helpers for the TAI list element decoder
`timescale 1ns / 1ps

package tle_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int LIST_W      = $clog2(MAX_ENTRIES + 1);
    localparam int QDEPTH      = 4;
    localparam int QPTR_W      = $clog2(QDEPTH);
    localparam int QCNT_W      = $clog2(QDEPTH + 1);

    localparam logic [1:0] KIND_ENTRY = 2'd0;
    localparam logic [1:0] KIND_DONE  = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    localparam logic [1:0] LT_NONCONSEC = 2'd0;
    localparam logic [1:0] LT_CONSEC    = 2'd1;
    localparam logic [1:0] LT_MANY_PLMN = 2'd2;
    localparam logic [1:0] LT_RESERVED  = 2'd3;

    localparam logic [8:0] ERR_IEI   = 9'd0;
    localparam logic [8:0] ERR_SHORT = 9'd1;
    localparam logic [8:0] ERR_COUNT = 9'd2;
    localparam logic [8:0] ERR_TYPE  = 9'd3;
    localparam logic [8:0] ERR_TRUNC = 9'd4;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_LEN,
        PH_HDR,
        PH_P0,
        PH_P1,
        PH_P2,
        PH_TH,
        PH_TL
    } phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_of_ie;
        logic [8:0] available_length;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [1:0]  list_type;
        logic [3:0]  list_index;
        logic [3:0]  entry_index;
        logic [4:0]  element_count;
        logic [11:0] mcc_bcd;
        logic [11:0] mnc_bcd;
        logic [15:0] tac;
        logic [8:0]  length_or_error;
        logic        last;
    } out_item_t;

    // classified byte as it sits in the queue
    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_of_ie;
        logic [8:0] available_length;
        logic       hdr2;
        logic       iei_bad;
    } q_item_t;

    function automatic out_item_t final_item(input logic [1:0] kind, input logic [8:0] code);
        out_item_t r;
        r                 = '0;
        r.kind            = kind;
        r.length_or_error = code;
        r.last            = 1'b1;
        return r;
    endfunction

endpackage

// File: hw/rtl/tle_front.sv
// Front end: config register, input transfer and start-byte classification
`timescale 1ns / 1ps

module tle_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [7:0]        cfg_wdata,
    input  logic              in_valid,
    output logic              in_ready,
    input  tle_pkg::in_item_t in_data,
    input  logic              q_full,
    output logic              q_push,
    output tle_pkg::q_item_t  q_push_data
);
    import tle_pkg::*;

    logic [7:0] expected_iei_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_iei_reg <= '0;
        end
        else if (cfg_we)
        begin
            expected_iei_reg <= cfg_wdata;
        end
    end

    assign in_ready = !q_full;
    assign q_push   = in_valid && !q_full;

    always_comb
    begin
        q_push_data.data_byte        = in_data.data_byte;
        q_push_data.start_of_ie      = in_data.start_of_ie;
        q_push_data.available_length = in_data.available_length;
        q_push_data.hdr2             = (expected_iei_reg != 8'd0);
        q_push_data.iei_bad          = (expected_iei_reg != 8'd0) &&
                                       (in_data.data_byte != expected_iei_reg);
    end

endmodule

// File: hw/rtl/tle_queue.sv
// Short FIFO of classified bytes between front and back
`timescale 1ns / 1ps

module tle_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  tle_pkg::q_item_t push_data,
    output logic             full,
    input  logic             pop,
    output logic             valid,
    output tle_pkg::q_item_t head
);
    import tle_pkg::*;

    q_item_t           mem [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    assign full  = (count_reg == QCNT_W'(QDEPTH));
    assign valid = (count_reg != '0);
    assign head  = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

endmodule

// File: hw/rtl/tle_back.sv
// Back end: element parser state machine and result output stage
`timescale 1ns / 1ps
`include "tai_list_ie_decoder_core_defines.svh"

module tle_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    input  tle_pkg::q_item_t   q_head,
    output logic               q_pop,
    output logic               out_valid,
    input  logic               out_ready,
    output tle_pkg::out_item_t out_data
);
    import tle_pkg::*;

    phase_t            phase_reg,   phase_next;
    logic [7:0]        vbs_reg,     vbs_next;
    logic [7:0]        ie_len_reg,  ie_len_next;
    logic [LIST_W-1:0] list_reg,    list_next;
    logic [4:0]        entry_reg,   entry_next;
    logic [4:0]        cnt_reg,     cnt_next;
    logic [1:0]        type_reg,    type_next;
    logic [23:0]       plmn_reg,    plmn_next;
    logic [7:0]        tac_hi_reg,  tac_hi_next;
    logic              hdr2_reg,    hdr2_next;
    logic [8:0]        avail_reg,   avail_next;

    logic              out_valid_reg, out_valid_next;
    out_item_t         out_reg,       out_next;
    logic              pend_valid_reg, pend_valid_next;
    out_item_t         pend_reg,      pend_next;

    out_item_t         r0;
    out_item_t         r1;
    logic [1:0]        n_res;

    // shared decode of the head byte
    logic [7:0]        b;
    logic              start;
    logic              start_iei;
    phase_t            eff_phase;
    logic              hdr2_eff;
    logic [8:0]        avail_eff;
    logic [8:0]        hdr_len;
    logic              short_buf;
    logic [7:0]        vbs_inc;
    logic              at_end;
    logic              cnt_big;
    logic [5:0]        cnt_p1;
    logic [4:0]        entry_inc;
    logic              list_done;
    logic [LIST_W-1:0] list_inc;
    logic              list_cap;
    logic              slot_free;

    assign b         = q_head.data_byte;
    assign start     = q_head.start_of_ie;
    assign start_iei = start && q_head.hdr2;
    assign eff_phase = start ? PH_LEN : phase_reg;
    assign hdr2_eff  = start ? q_head.hdr2 : hdr2_reg;
    assign avail_eff = start ? q_head.available_length : avail_reg;
    assign hdr_len   = hdr2_eff ? 9'd2 : 9'd1;
    assign short_buf = avail_eff < (hdr_len + {1'b0, b});
    assign vbs_inc   = vbs_reg + 8'd1;
    assign at_end    = (vbs_inc == ie_len_reg);
    assign cnt_big   = ({1'b0, b[4:0]} + 6'd1) > 6'(MAX_ENTRIES);
    assign cnt_p1    = {1'b0, cnt_reg} + 6'd1;
    assign entry_inc = entry_reg + 5'd1;
    assign list_done = (type_reg == LT_CONSEC) || ({1'b0, entry_inc} == cnt_p1);
    assign list_inc  = list_reg + LIST_W'(1);
    assign list_cap  = list_inc >= LIST_W'(MAX_ENTRIES);

    assign slot_free = !out_valid_reg || out_ready;
    assign q_pop     = q_valid && !pend_valid_reg && slot_free;

    // next state of the parser
    always_comb
    begin
        phase_next  = phase_reg;
        vbs_next    = vbs_reg;
        ie_len_next = ie_len_reg;
        list_next   = list_reg;
        entry_next  = entry_reg;
        cnt_next    = cnt_reg;
        type_next   = type_reg;
        plmn_next   = plmn_reg;
        tac_hi_next = tac_hi_reg;
        hdr2_next   = hdr2_reg;
        avail_next  = avail_reg;
        if (start)
        begin
            avail_next  = q_head.available_length;
            hdr2_next   = q_head.hdr2;
            vbs_next    = '0;
            ie_len_next = '0;
            list_next   = '0;
            entry_next  = '0;
            cnt_next    = '0;
            type_next   = '0;
            plmn_next   = '0;
            tac_hi_next = '0;
        end
        if (start_iei)
        begin
            phase_next = q_head.iei_bad ? PH_IDLE : PH_LEN;
        end
        else
        begin
            case (eff_phase)
                PH_IDLE:
                begin
                    phase_next = PH_IDLE;
                end
                PH_LEN:
                begin
                    ie_len_next = b;
                    vbs_next    = '0;
                    phase_next  = (short_buf || b == 8'd0) ? PH_IDLE : PH_HDR;
                end
                PH_HDR:
                begin
                    vbs_next   = vbs_inc;
                    type_next  = b[6:5];
                    cnt_next   = b[4:0];
                    entry_next = '0;
                    phase_next = (cnt_big || b[6:5] == LT_RESERVED || at_end) ?
                                 PH_IDLE : PH_P0;
                end
                PH_P0:
                begin
                    vbs_next   = vbs_inc;
                    plmn_next  = {b, 16'h0000};
                    phase_next = at_end ? PH_IDLE : PH_P1;
                end
                PH_P1:
                begin
                    vbs_next   = vbs_inc;
                    plmn_next  = {plmn_reg[23:16], b, 8'h00};
                    phase_next = at_end ? PH_IDLE : PH_P2;
                end
                PH_P2:
                begin
                    vbs_next   = vbs_inc;
                    plmn_next  = {plmn_reg[23:8], b};
                    phase_next = at_end ? PH_IDLE : PH_TH;
                end
                PH_TH:
                begin
                    vbs_next    = vbs_inc;
                    tac_hi_next = b;
                    phase_next  = at_end ? PH_IDLE : PH_TL;
                end
                PH_TL:
                begin
                    vbs_next   = vbs_inc;
                    entry_next = entry_inc;
                    if (!list_done)
                    begin
                        phase_next = at_end ? PH_IDLE :
                                     (type_reg == LT_NONCONSEC) ? PH_TH : PH_P0;
                    end
                    else
                    begin
                        list_next  = list_inc;
                        phase_next = (at_end || list_cap) ? PH_IDLE : PH_HDR;
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    // results caused by the head byte
    always_comb
    begin
        r0    = '0;
        r1    = '0;
        n_res = 2'd0;
        if (start_iei)
        begin
            if (q_head.iei_bad)
            begin
                r0    = final_item(KIND_ERROR, ERR_IEI);
                n_res = 2'd1;
            end
        end
        else
        begin
            case (eff_phase)
                PH_IDLE:
                begin
                    n_res = 2'd0;
                end
                PH_LEN:
                begin
                    if (short_buf)
                    begin
                        r0    = final_item(KIND_ERROR, ERR_SHORT);
                        n_res = 2'd1;
                    end
                    else if (b == 8'd0)
                    begin
                        r0    = final_item(KIND_DONE, hdr_len);
                        n_res = 2'd1;
                    end
                end
                PH_HDR:
                begin
                    if (cnt_big)
                    begin
                        r0    = final_item(KIND_ERROR, ERR_COUNT);
                        n_res = 2'd1;
                    end
                    else if (b[6:5] == LT_RESERVED)
                    begin
                        r0    = final_item(KIND_ERROR, ERR_TYPE);
                        n_res = 2'd1;
                    end
                    else if (at_end)
                    begin
                        r0    = final_item(KIND_ERROR, ERR_TRUNC);
                        n_res = 2'd1;
                    end
                end
                PH_P0, PH_P1, PH_P2, PH_TH:
                begin
                    if (at_end)
                    begin
                        r0    = final_item(KIND_ERROR, ERR_TRUNC);
                        n_res = 2'd1;
                    end
                end
                PH_TL:
                begin
                    r0.kind          = KIND_ENTRY;
                    r0.list_type     = type_reg;
                    r0.list_index    = list_reg[3:0];
                    r0.entry_index   = entry_reg[3:0];
                    r0.element_count = cnt_p1[4:0];
                    r0.mcc_bcd       = {plmn_reg[19:16], plmn_reg[23:20], plmn_reg[11:8]};
                    r0.mnc_bcd       = {plmn_reg[3:0], plmn_reg[7:4], plmn_reg[15:12]};
                    r0.tac           = {tac_hi_reg, b};
                    n_res            = 2'd1;
                    if (!list_done)
                    begin
                        if (at_end)
                        begin
                            r1    = final_item(KIND_ERROR, ERR_TRUNC);
                            n_res = 2'd2;
                        end
                    end
                    else if (at_end || list_cap)
                    begin
                        r1    = final_item(KIND_DONE, hdr_len + {1'b0, vbs_inc});
                        n_res = 2'd2;
                    end
                end
                default:
                begin
                    n_res = 2'd0;
                end
            endcase
        end
    end

    // output register plus one pending slot for the second result
    always_comb
    begin
        out_valid_next  = out_valid_reg && !out_ready;
        out_next        = out_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        if (pend_valid_reg && slot_free)
        begin
            out_valid_next  = 1'b1;
            out_next        = pend_reg;
            pend_valid_next = 1'b0;
        end
        else if (q_pop && n_res != 2'd0)
        begin
            out_valid_next = 1'b1;
            out_next       = r0;
            if (n_res == 2'd2)
            begin
                pend_valid_next = 1'b1;
                pend_next       = r1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            vbs_reg        <= '0;
            ie_len_reg     <= '0;
            list_reg       <= '0;
            entry_reg      <= '0;
            cnt_reg        <= '0;
            type_reg       <= '0;
            hdr2_reg       <= 1'b0;
            avail_reg      <= '0;
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                phase_reg  <= phase_next;
                vbs_reg    <= vbs_next;
                ie_len_reg <= ie_len_next;
                list_reg   <= list_next;
                entry_reg  <= entry_next;
                cnt_reg    <= cnt_next;
                type_reg   <= type_next;
                hdr2_reg   <= hdr2_next;
                avail_reg  <= avail_next;
            end
            out_valid_reg  <= out_valid_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            plmn_reg   <= plmn_next;
            tac_hi_reg <= tac_hi_next;
        end
        out_reg  <= out_next;
        pend_reg <= pend_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    `TLE_ASSERT_HOLDS(a_pend_behind_out, pend_valid_reg, out_valid_reg, "pending result without output")
    `TLE_ASSERT_HOLDS(a_pend_is_final, pend_valid_reg, pend_reg.last, "second result not final")
    `TLE_ASSERT_HOLDS(a_entry_not_last, out_valid_reg && out_reg.kind == KIND_ENTRY, !out_reg.last, "entry marked last")
    `TLE_ASSERT_HOLDS(a_idle_after_pair, $rose(pend_valid_reg), phase_reg == PH_IDLE, "parser active after final pair")
    `TLE_ASSERT_NEXT(a_pair_parks, q_pop && n_res == 2'd2, pend_valid_reg, "second result dropped")

endmodule

// File: hw/rtl/tai_list_ie_decoder_core.sv
// Top level of the tracking area identity list element decoder
`timescale 1ns / 1ps

// Usage:
//   in channel (in_valid/in_ready/in_data): one element byte per transfer, with
//   start_of_ie set on the first byte and available_length sampled there.
//   out channel (out_valid/out_ready/out_data): one result per transfer; area
//   entries, then a done or error result with last set.
//   cfg_we/cfg_wdata write expected_iei; write only while idle.
// A byte reaches out_valid through the queue and then the output register.
// Throughput: one byte per cycle while the receiver takes results. A byte that
//   yields two results (last entry plus done or error) holds the parser until
//   the first result leaves the output register.
// A four-entry byte queue sits between the front end and the parser, so the
//   input keeps taking bytes while the receiver stalls, until the queue fills.
// Reset clears the queue, the output stage, the parser (idle) and expected_iei
//   (zero: no identifier byte before the length).
// start_of_ie on any byte abandons the current element and begins a new one.

module tai_list_ie_decoder_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [7:0]         cfg_wdata,
    input  logic               in_valid,
    output logic               in_ready,
    input  tle_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output tle_pkg::out_item_t out_data
);
    import tle_pkg::*;

    logic    q_push;
    q_item_t q_push_data;
    logic    q_full;
    logic    q_pop;
    logic    q_valid;
    q_item_t q_head;

    tle_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_data     (in_data),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_push_data (q_push_data)
    );

    tle_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .head      (q_head)
    );

    tle_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule
